// ===== src/pmsfa_pkg.sv =====
package pmsfa_pkg;

  localparam int MAX_FRAMES  = 255;
  localparam int FRAME_LIMIT = (MAX_FRAMES > 255) ? 255 : MAX_FRAMES;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] CMD_BYTE = 8'hC0;
  localparam int         DATA_LEN = 6;

  localparam int SUM_W  = 21;
  localparam int CNT_W  = 8;
  localparam int RD_W   = 13;
  localparam int MEAN_W = SUM_W + 8;
  localparam int STEP_W = $clog2(MEAN_W);
  localparam int PROD_W = 16 + MEAN_W + 1;

  // Multiply by this and shift right by DIV10_SHIFT to divide a 16-bit value by ten.
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [0:0] REG_SLOPE     = 1'b0;
  localparam logic [0:0] REG_INTERCEPT = 1'b1;

  localparam logic [15:0] SLOPE_RESET     = 16'd4096;
  localparam logic [23:0] INTERCEPT_RESET = 24'd0;

  localparam logic [23:0] Q8_MAX = 24'h7FFFFF;
  localparam logic [23:0] Q8_MIN = 24'h800000;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NO_FRAMES = 1'b1;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_CMD,
    PH_DATA,
    PH_CHECK
  } parse_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             corr;
  } window_t;

endpackage

// ===== src/pmsfa_if.sv =====
interface pmsfa_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       apply_correction;

  modport source (output valid, req_type, rx_byte, apply_correction, input ready);
  modport sink (input valid, req_type, rx_byte, apply_correction, output ready);
endinterface

interface pmsfa_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  frame_total;
  logic [23:0] pm25_q8;

  modport source (output valid, status, frame_total, pm25_q8, input ready);
  modport sink (input valid, status, frame_total, pm25_q8, output ready);
endinterface

interface pmsfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pmsfa_front.sv =====
module pmsfa_front (
  input  logic               clk,
  input  logic               rst_n,
  pmsfa_in_if.sink           in_ch,
  input  logic               q_full,
  output logic               push,
  output pmsfa_pkg::window_t push_data
);

  pmsfa_pkg::parse_phase_t phase_r, phase_nxt;
  logic [2:0]                 pos_r, pos_nxt;
  logic [7:0]                 check_r, check_nxt;
  logic [15:0]                value_r, value_nxt;
  logic [pmsfa_pkg::RD_W-1:0] reading_r;
  logic [pmsfa_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [pmsfa_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [32:0]                div_prod;
  logic [pmsfa_pkg::SUM_W:0]  sum_ext;
  logic                       take;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  // The reading is registered from value_r; the checksum byte comes at least four bytes later.
  assign div_prod = {1'b0, value_r} * {16'd0, pmsfa_pkg::DIV10_MUL};
  assign sum_ext  = {1'b0, sum_r} + {{(pmsfa_pkg::SUM_W + 1 - pmsfa_pkg::RD_W){1'b0}}, reading_r};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    check_nxt = check_r;
    value_nxt = value_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (take && in_ch.req_type) begin
      phase_nxt = pmsfa_pkg::PH_HEAD;
      pos_nxt   = 3'd0;
      check_nxt = 8'd0;
      value_nxt = 16'd0;
      sum_nxt   = '0;
      count_nxt = '0;
    end else if (take) begin
      case (phase_r)
        pmsfa_pkg::PH_HEAD: begin
          if (in_ch.rx_byte == pmsfa_pkg::HDR_BYTE) begin
            phase_nxt = pmsfa_pkg::PH_CMD;
          end
        end
        pmsfa_pkg::PH_CMD: begin
          if (in_ch.rx_byte == pmsfa_pkg::CMD_BYTE) begin
            phase_nxt = pmsfa_pkg::PH_DATA;
            pos_nxt   = 3'd0;
            check_nxt = 8'd0;
            value_nxt = 16'd0;
          end else begin
            phase_nxt = pmsfa_pkg::PH_HEAD;
          end
        end
        pmsfa_pkg::PH_DATA: begin
          check_nxt = check_r + in_ch.rx_byte;
          if (pos_r == 3'd0) begin
            value_nxt[7:0] = in_ch.rx_byte;
          end
          if (pos_r == 3'd1) begin
            value_nxt[15:8] = in_ch.rx_byte;
          end
          pos_nxt = pos_r + 3'd1;
          if (pos_r == 3'(pmsfa_pkg::DATA_LEN - 1)) begin
            phase_nxt = pmsfa_pkg::PH_CHECK;
          end
        end
        default: begin
          if (in_ch.rx_byte == check_r &&
              count_r < pmsfa_pkg::CNT_W'(pmsfa_pkg::FRAME_LIMIT)) begin
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_ext[pmsfa_pkg::SUM_W] ? {pmsfa_pkg::SUM_W{1'b1}}
                                                  : sum_ext[pmsfa_pkg::SUM_W-1:0];
          end
          phase_nxt = pmsfa_pkg::PH_HEAD;
          pos_nxt   = 3'd0;
          check_nxt = 8'd0;
          value_nxt = 16'd0;
        end
      endcase
    end
  end

  always_comb begin
    push            = take && in_ch.req_type;
    push_data.sum   = sum_r;
    push_data.count = count_r;
    push_data.corr  = in_ch.apply_correction;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pmsfa_pkg::PH_HEAD;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    check_r   <= check_nxt;
    value_r   <= value_nxt;
    reading_r <= div_prod[pmsfa_pkg::DIV10_SHIFT +: pmsfa_pkg::RD_W];
  end

endmodule

// ===== src/pmsfa_queue.sv =====
module pmsfa_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pmsfa_pkg::window_t push_data,
  input  logic               pop,
  output pmsfa_pkg::window_t head,
  output logic               full,
  output logic               empty
);

  pmsfa_pkg::window_t              entry_r [pmsfa_pkg::QUEUE_DEPTH];
  logic [pmsfa_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [pmsfa_pkg::QCNT_W-1:0]    count_r;

  assign full  = count_r == pmsfa_pkg::QCNT_W'(pmsfa_pkg::QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("Request pushed into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("Request popped from an empty queue.");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= pmsfa_pkg::QCNT_W'(pmsfa_pkg::QUEUE_DEPTH))
    else $error("Queue fill count exceeds the depth.");

endmodule

// ===== src/pmsfa_back.sv =====
module pmsfa_back (
  input  logic               clk,
  input  logic               rst_n,
  pmsfa_cfg_if.sink          cfg_ch,
  input  logic               q_empty,
  input  pmsfa_pkg::window_t q_head,
  output logic               pop,
  pmsfa_out_if.source        out_ch
);

  pmsfa_pkg::back_state_t state_r, state_nxt;

  logic [15:0]                   slope_r;
  logic [23:0]                   intercept_r;
  logic [pmsfa_pkg::MEAN_W-1:0]  dividend_r, quot_r;
  logic [7:0]                    rem_r, divisor_r;
  logic [pmsfa_pkg::STEP_W-1:0]  step_r;
  logic                          corr_r, no_frames_r;
  logic [pmsfa_pkg::CNT_W-1:0]   total_r;
  logic signed [pmsfa_pkg::PROD_W-1:0] prod_r;
  logic                          out_valid_r, out_status_r;
  logic [7:0]                    out_total_r;
  logic [23:0]                   out_pm_r;

  logic [8:0]                    rem_sh, rem_sub;
  logic                          rem_ge, div_last, out_free, load_out;
  logic signed [pmsfa_pkg::PROD_W-1:0] prod_sh;
  logic signed [pmsfa_pkg::PROD_W:0]   final_val;
  logic [23:0]                   final_pm;

  assign cfg_ch.ready = 1'b1;

  assign rem_sh   = {rem_r, dividend_r[pmsfa_pkg::MEAN_W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor_r};
  assign rem_ge   = rem_sh >= {1'b0, divisor_r};
  assign div_last = step_r == pmsfa_pkg::STEP_W'(pmsfa_pkg::MEAN_W - 1);
  assign out_free = !out_valid_r || out_ch.ready;

  // Arithmetic shift right gives the floor of the division by 4096.
  assign prod_sh = prod_r >>> 12;

  always_comb begin
    if (corr_r) begin
      final_val = {prod_sh[pmsfa_pkg::PROD_W-1], prod_sh} +
                  {{(pmsfa_pkg::PROD_W + 1 - 24){intercept_r[23]}}, intercept_r};
    end else begin
      final_val = {{(pmsfa_pkg::PROD_W + 1 - pmsfa_pkg::MEAN_W){1'b0}}, quot_r};
    end
    if (no_frames_r) begin
      final_pm = 24'd0;
    end else if (final_val > $signed({{(pmsfa_pkg::PROD_W + 1 - 24){1'b0}}, pmsfa_pkg::Q8_MAX})) begin
      final_pm = pmsfa_pkg::Q8_MAX;
    end else if (final_val < $signed({{(pmsfa_pkg::PROD_W + 1 - 24){1'b1}}, pmsfa_pkg::Q8_MIN})) begin
      final_pm = pmsfa_pkg::Q8_MIN;
    end else begin
      final_pm = final_val[23:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmsfa_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_head.count == '0) ? pmsfa_pkg::BK_OUT : pmsfa_pkg::BK_DIV;
        end
      end
      pmsfa_pkg::BK_DIV: begin
        if (div_last) begin
          state_nxt = corr_r ? pmsfa_pkg::BK_MUL : pmsfa_pkg::BK_OUT;
        end
      end
      pmsfa_pkg::BK_MUL: begin
        state_nxt = pmsfa_pkg::BK_OUT;
      end
      default: begin
        if (out_free) begin
          state_nxt = pmsfa_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      pmsfa_pkg::BK_IDLE: pop      = !q_empty;
      pmsfa_pkg::BK_OUT:  load_out = out_free;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmsfa_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      slope_r     <= pmsfa_pkg::SLOPE_RESET;
      intercept_r <= pmsfa_pkg::INTERCEPT_RESET;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.index == pmsfa_pkg::REG_SLOPE) begin
        slope_r <= cfg_ch.data[15:0];
      end
      if (cfg_ch.valid && cfg_ch.index == pmsfa_pkg::REG_INTERCEPT) begin
        intercept_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dividend_r  <= {q_head.sum, 8'd0};
      quot_r      <= '0;
      rem_r       <= 8'd0;
      divisor_r   <= q_head.count;
      step_r      <= '0;
      corr_r      <= q_head.corr;
      total_r     <= q_head.count;
      no_frames_r <= q_head.count == '0;
    end else if (state_r == pmsfa_pkg::BK_DIV) begin
      dividend_r <= {dividend_r[pmsfa_pkg::MEAN_W-2:0], 1'b0};
      quot_r     <= {quot_r[pmsfa_pkg::MEAN_W-2:0], rem_ge};
      rem_r      <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
      step_r     <= step_r + 1'b1;
    end
    if (state_r == pmsfa_pkg::BK_MUL) begin
      prod_r <= pmsfa_pkg::PROD_W'($signed(slope_r)) *
                pmsfa_pkg::PROD_W'($signed({1'b0, quot_r}));
    end
    if (load_out) begin
      out_status_r <= no_frames_r ? pmsfa_pkg::STATUS_NO_FRAMES : pmsfa_pkg::STATUS_OK;
      out_total_r  <= total_r;
      out_pm_r     <= final_pm;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.frame_total = out_total_r;
  assign out_ch.pm25_q8     = out_pm_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == pmsfa_pkg::BK_DIV |-> divisor_r != 8'd0)
    else $error("Divide started on an empty window.");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == pmsfa_pkg::BK_DIV |-> rem_r < divisor_r)
    else $error("Partial remainder not below the divisor.");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
      load_out |=> out_valid_r)
    else $error("Loaded result not presented.");

endmodule

// ===== src/pm_sensor_frame_averager.sv =====
// PM2.5 frame averager.
// in_ch takes one request per accepted handshake: a received UART byte
// (req_type 0) or a finish request (req_type 1). Bytes feed the frame
// parser at one per cycle while in_ch is ready, and never produce a result.
// A finish request snapshots the window's sum and frame count into a
// two-entry queue, clears the window and restarts the parser in the same
// cycle, so bytes of the next window keep flowing while the mean is worked out.
// The back end pops a window and divides with a radix-2 restoring divider,
// one quotient bit per cycle over the 29 quotient bits, then does the
// slope multiply in the BK_MUL state when correction is requested. A
// finish request's window goes from the queue through the divide, the
// multiply with correction and the out_ch register; an empty window skips
// the divide. A new window is popped only after the last result is loaded.
// in_ch.ready drops only while the queue holds two unfinished windows.
// out_ch is a registered output; when the receiver stalls, the result holds
// and the back end waits, so the queue fills and then input stalls.
// cfg_ch writes slope (index 0) and intercept (index 1) at any time it is
// valid; it is always ready. Reset clears the window, the parser and the
// queue, and sets slope to 1.0 and intercept to zero.
module pm_sensor_frame_averager (
  input  logic         clk,
  input  logic         rst_n,
  pmsfa_in_if.sink     in_ch,
  pmsfa_out_if.source  out_ch,
  pmsfa_cfg_if.sink    cfg_ch
);

  logic               push, pop, q_full, q_empty;
  pmsfa_pkg::window_t push_data, q_head;

  pmsfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pmsfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pmsfa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
